FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the priority queue.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check once out of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/spq_pkg.sv
// Types and codes of the sorted-array priority queue.
// Used by the channel interfaces, the cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic signed [15:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/spq_channels.sv
// Valid/ready channel interfaces of the priority queue: command beats in,
// result beats out. Depends on spq_pkg for the command and status codes.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
  logic                valid;
  logic                ready;
  spq_pkg::cmd_t       cmd;
  logic signed [31:0]  item_value;
  logic signed [15:0]  item_priority;

  modport source (output valid, cmd, item_value, item_priority, input ready);
  modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                valid;
  logic                ready;
  spq_pkg::status_t    status;
  logic signed [31:0]  removed_value;
  logic signed [15:0]  removed_priority;
  logic                now_empty;
  logic                now_full;

  modport source (output valid, status, removed_value, removed_priority, now_empty,
                  now_full, input ready);
  modport sink   (input valid, status, removed_value, removed_priority, now_empty,
                  now_full, output ready);
endinterface

`default_nettype wire

FILE: design/spq_cell.sv
// One slot of the sorted array: holds one entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and control types.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  input  wire logic               left_keep,
  input  wire logic               occupied,
  output spq_pkg::entry_t         entry_r,
  output logic                    keep
);

  spq_pkg::entry_t entry_nxt;

  // Stay put when this entry outranks or ties the new one.
  assign keep = occupied && ($signed(entry_r.prio) >= $signed(ctrl.item.prio));

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      spq_pkg::OP_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (left_keep) begin
          entry_nxt = ctrl.item;
        end else begin
          entry_nxt = left_entry;
        end
      end
      spq_pkg::OP_REMOVE: entry_nxt = right_entry;
      default:            entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

FILE: design/sorted_array_priority_queue_top.sv
// Top level of the sorted-array priority queue: a row of spq_cell slots,
// the occupancy count and the result register. Depends on spq_pkg and spq_channels.
//
//   channel   dir  beat contents
//   in_if     in   cmd, item_value, item_priority
//   out_if    out  status, removed_value, removed_priority, now_empty, now_full
//
// One command beat per cycle while no result stalls; each gives one result beat in
// the next cycle. Inserts and removes update all cells at once: every cell compares
// its priority with the new one and shifts left or right in parallel.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// A stalled result holds in_if.ready low until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_if,
  spq_out_if.source  out_if
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic                out_valid_r;
  spq_pkg::status_t    status_r, status_nxt;
  logic signed [31:0]  rem_val_r, rem_val_nxt;
  logic signed [15:0]  rem_prio_r, rem_prio_nxt;
  logic                empty_r, full_r;

  logic                accept, is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries [CAPACITY];
  logic [CAPACITY-1:0] keep;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_full     = (occ_r == OCC_W'(CAPACITY));
  assign is_empty    = (occ_r == '0);

  always_comb begin
    ctrl.item.val  = in_if.item_value;
    ctrl.item.prio = in_if.item_priority;
    ctrl.op        = spq_pkg::OP_HOLD;
    status_nxt     = spq_pkg::ST_DONE;
    rem_val_nxt    = '0;
    rem_prio_nxt   = '0;
    occ_nxt        = occ_r;
    if (in_if.cmd == spq_pkg::CMD_INSERT) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        ctrl.op = accept ? spq_pkg::OP_INSERT : spq_pkg::OP_HOLD;
        occ_nxt = occ_r + OCC_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        ctrl.op      = accept ? spq_pkg::OP_REMOVE : spq_pkg::OP_HOLD;
        occ_nxt      = occ_r - OCC_W'(1);
        rem_val_nxt  = entries[0].val;
        rem_prio_nxt = entries[0].prio;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_k;

    if (i == 0) begin : g_head
      assign left_e = ctrl.item;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_e = entries[i-1];
      assign left_k = keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_next
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .occupied    (OCC_W'(i) < occ_r),
      .entry_r     (entries[i]),
      .keep        (keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r <= occ_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      rem_val_r  <= rem_val_nxt;
      rem_prio_r <= rem_prio_nxt;
      empty_r    <= (occ_nxt == '0);
      full_r     <= (occ_nxt == OCC_W'(CAPACITY));
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = status_r;
  assign out_if.removed_value    = rem_val_r;
  assign out_if.removed_priority = rem_prio_r;
  assign out_if.now_empty        = empty_r;
  assign out_if.now_full         = full_r;

endmodule

`default_nettype wire

FILE: design/spq_checker.sv
// Port-level checks on the priority queue's result channel, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire spq_pkg::status_t   out_status,
  input wire logic signed [31:0] out_removed_value,
  input wire logic               out_now_empty,
  input wire logic               out_now_full
);

  `SPQ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result beat right after reset")
  `SPQ_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid, "stalled beat dropped")
  `SPQ_ASSERT(a_not_both, out_valid |-> !(out_now_empty && out_now_full), "empty and full at once")
  `SPQ_ASSERT(a_full_drop, out_valid && out_status == spq_pkg::ST_FULL |-> out_now_full && out_removed_value == 32'sd0, "dropped insert without full queue")
  `SPQ_ASSERT(a_empty_remove, out_valid && out_status == spq_pkg::ST_EMPTY |-> out_now_empty && out_removed_value == 32'sd0, "empty remove with entries held")

endmodule

bind sorted_array_priority_queue_top spq_checker u_spq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_status        (out_if.status),
  .out_removed_value (out_if.removed_value),
  .out_now_empty     (out_if.now_empty),
  .out_now_full      (out_if.now_full)
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of sorted_array_priority_queue_top: random and directed insert/remove
// beats, a local sorted-queue predictor and an in-order result check.
// Depends on spq_pkg, spq_channels and the design sources.
`timescale 1ns / 1ps

module tb;

  localparam int CAP        = 64;
  localparam int QUIET_TAIL = 40;
  localparam int CYCLE_CAP  = 200000;

  typedef struct {
    spq_pkg::cmd_t      cmd;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } pq_cmd_t;

  typedef struct {
    spq_pkg::status_t   status;
    logic signed [31:0] value;
    logic signed [15:0] prio;
    logic               now_empty;
    logic               now_full;
  } pq_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_array_priority_queue_top #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pq_cmd_t            pending_beats[$];
  pq_result_t         expected_results[$];
  logic signed [31:0] model_values[CAP];
  logic signed [15:0] model_prios[CAP];
  int                 model_held;
  int                 planned_held;
  int                 in_gap;
  int                 out_stall;
  int                 errors;
  int                 cycles;
  pq_cmd_t            next_beat;
  pq_cmd_t            seen_beat;
  pq_result_t         got;
  pq_result_t         want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pq_result_t apply_beat(pq_cmd_t b);
    pq_result_t r;
    int pos;
    r.status = spq_pkg::ST_DONE;
    r.value = '0;
    r.prio = '0;
    if (b.cmd == spq_pkg::CMD_INSERT) begin
      if (model_held >= CAP) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = model_held;
        while (pos > 0 && model_prios[pos - 1] < b.prio) begin
          model_values[pos] = model_values[pos - 1];
          model_prios[pos] = model_prios[pos - 1];
          pos--;
        end
        model_values[pos] = b.value;
        model_prios[pos] = b.prio;
        model_held++;
      end
    end else begin
      if (model_held == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.value = model_values[0];
        r.prio = model_prios[0];
        for (int k = 0; k + 1 < model_held; k++) begin
          model_values[k] = model_values[k + 1];
          model_prios[k] = model_prios[k + 1];
        end
        model_held--;
      end
    end
    r.now_empty = (model_held == 0);
    r.now_full = (model_held >= CAP);
    return r;
  endfunction

  task automatic queue_beat(spq_pkg::cmd_t c, logic [31:0] v, logic [15:0] p);
    pq_cmd_t b;
    b.cmd = c;
    b.value = v;
    b.prio = p;
    pending_beats.push_back(b);
    if (c == spq_pkg::CMD_INSERT && planned_held < CAP) planned_held++;
    if (c == spq_pkg::CMD_REMOVE && planned_held > 0) planned_held--;
  endtask

  function automatic logic [15:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel < 2) return 16'($signed($urandom_range(0, 6)) - 3);
    if (sel == 2) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic random_beat(int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) begin
      queue_beat(spq_pkg::CMD_INSERT, $urandom, pick_prio());
    end else begin
      queue_beat(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= spq_pkg::CMD_INSERT;
      in_ch.item_value <= '0;
      in_ch.item_priority <= '0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= next_beat.cmd;
        in_ch.item_value <= next_beat.value;
        in_ch.item_priority <= next_beat.prio;
        if (pending_beats.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
          in_gap <= $urandom_range(1, 10);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (pending_beats.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: check the result beat, then predict the accepted command beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.value = out_ch.removed_value;
        got.prio = out_ch.removed_priority;
        got.now_empty = out_ch.now_empty;
        got.now_full = out_ch.now_full;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d", $time, got.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("removed_value", want.value, got.value);
          check_field("removed_priority", want.prio, got.prio);
          check_field("now_empty", want.now_empty, got.now_empty);
          check_field("now_full", want.now_full, got.now_full);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_beat.cmd = in_ch.cmd;
        seen_beat.value = in_ch.item_value;
        seen_beat.prio = in_ch.item_priority;
        expected_results.push_back(apply_beat(seen_beat));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    errors = 0;
    model_held = 0;
    planned_held = 0;

    // remove on empty, extremes, ties in arrival order, then drain past empty
    queue_beat(spq_pkg::CMD_REMOVE, 32'hffffffff, 16'hffff);
    queue_beat(spq_pkg::CMD_INSERT, 32'h7fffffff, 16'h7fff);
    queue_beat(spq_pkg::CMD_INSERT, 32'h80000000, 16'h8000);
    queue_beat(spq_pkg::CMD_INSERT, 32'h00000000, 16'h0000);
    queue_beat(spq_pkg::CMD_INSERT, 32'hffffffff, 16'hffff);
    queue_beat(spq_pkg::CMD_INSERT, 32'h00000005, 16'h0000);
    queue_beat(spq_pkg::CMD_INSERT, 32'h55555555, 16'h5555);
    queue_beat(spq_pkg::CMD_INSERT, 32'haaaaaaaa, 16'haaaa);
    queue_beat(spq_pkg::CMD_INSERT, 32'h00000006, 16'h0000);
    repeat (9) queue_beat(spq_pkg::CMD_REMOVE, 32'h0, 16'h0);

    // fill past full, drain past empty, then mixed traffic
    while (planned_held < CAP) random_beat(90);
    repeat ($urandom_range(1, 3)) queue_beat(spq_pkg::CMD_INSERT, $urandom, pick_prio());
    while (planned_held > 0) random_beat(10);
    repeat ($urandom_range(1, 2)) queue_beat(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));
    while (pending_beats.size() < 400) random_beat(55);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/spq_pkg.sv
design/spq_channels.sv
design/spq_cell.sv
design/sorted_array_priority_queue_top.sv
design/spq_checker.sv
tb/tb.sv
